[hw/rtl/event_slot_scheduler_assert.svh]
// assertion macros for the event slot scheduler, sampled on clock, off during reset
`ifndef EVENT_SLOT_SCHEDULER_ASSERT_SVH
`define EVENT_SLOT_SCHEDULER_ASSERT_SVH

// consequent checked in the same cycle
`define ESS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ess_pkg.sv]
`default_nettype none

package ess_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_ELAPSE = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_FIRED = 2'd0,
      KIND_NEXT  = 2'd1,
      KIND_STATE = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_UNUSED = 2'd0,
      ST_NEW    = 2'd1,
      ST_USED   = 2'd2
   } slot_status_type;

   localparam logic [31:0] NO_CANDIDATE = 32'hFFFF_FFFF;

   typedef struct packed {
      func_type           func;
      logic [2:0]         slot_id;
      logic [31:0]        period;
      logic signed [15:0] repeat_count;
      logic [31:0]        elapsed_ticks;
   } req_type;

   typedef struct packed {
      kind_type        kind;
      logic [2:0]      event_id;
      logic [31:0]     next_delay;
      logic            timer_on;
      slot_status_type slot_state;
      logic            last;
   } rsp_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_WALK,
      CS_DRAIN,
      CS_REPORT
   } ctl_state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ADD,
      ACT_ZERO_ADD,
      ACT_REMOVE,
      ACT_QUERY,
      ACT_REJECT,
      ACT_REPORT
   } act_type;

   typedef struct packed {
      logic    capture;
      logic    walk_init;
      logic    walk_step;
      act_type act;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     in_range;
      logic     period_zero;
      logic     walk_last;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/ess_ctrl.sv]
`default_nettype none

module ess_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ess_pkg::dp_status_type status,
   output ess_pkg::dp_cmd_type   cmd
);
   import ess_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '{capture: 1'b0, walk_init: 1'b0, walk_step: 1'b0, act: ACT_NONE};
      busy     = 1'b1;
      unique case (state_ff)
         CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = CS_DECODE;
            end
         end
         CS_DECODE: begin
            if (status.func == FUNC_ELAPSE) begin
               cmd.walk_init = 1'b1;
               state_in      = CS_WALK;
            end else if (!status.in_range) begin
               cmd.act  = ACT_REJECT;
               state_in = CS_IDLE;
            end else begin
               unique case (status.func)
                  FUNC_ADD: begin
                     if (status.period_zero) begin
                        cmd.act  = ACT_ZERO_ADD;
                        state_in = CS_IDLE;
                     end else begin
                        // slot write and walk start share this cycle
                        cmd.act       = ACT_ADD;
                        cmd.walk_init = 1'b1;
                        state_in      = CS_WALK;
                     end
                  end
                  FUNC_REMOVE: begin
                     cmd.act  = ACT_REMOVE;
                     state_in = CS_IDLE;
                  end
                  default: begin
                     cmd.act  = ACT_QUERY;
                     state_in = CS_IDLE;
                  end
               endcase
            end
         end
         CS_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = CS_DRAIN;
            end
         end
         CS_DRAIN: begin
            // minimum stage takes in the last slot
            state_in = CS_REPORT;
         end
         CS_REPORT: begin
            cmd.act  = ACT_REPORT;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/ess_datapath.sv]
`default_nettype none

module ess_datapath #(
   parameter int SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ess_pkg::req_type       req_item,
   input  ess_pkg::dp_cmd_type    cmd,
   output ess_pkg::dp_status_type status,
   output logic                  rsp_valid,
   output ess_pkg::rsp_type       rsp_item
);
   import ess_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   slot_status_type    status_ff [SLOTS];
   logic [31:0]        time_ff   [SLOTS];
   logic [31:0]        period_ff [SLOTS];
   logic [15:0]        reps_ff   [SLOTS];

   req_type            req_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;

   logic               cand_valid_ff;
   logic               cand_valid_in;
   logic [31:0]        cand_time_ff;
   logic [IDX_W-1:0]   cand_idx_ff;
   logic               best_found_ff;
   logic               best_found_in;
   logic [31:0]        best_time_ff;
   logic [31:0]        best_time_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [IDX_W-1:0]   best_idx_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [IDX_W-1:0]   req_addr;
   logic [IDX_W-1:0]   addr;
   slot_status_type    cur_status;
   logic [31:0]        cur_time;
   logic [31:0]        cur_period;
   logic [15:0]        cur_reps;
   logic [31:0]        sat_time;
   slot_status_type    st1;
   logic [31:0]        t1;
   logic               fire;
   slot_status_type    st2;
   logic [31:0]        t2;
   logic [15:0]        reps2;

   logic               wr_en;
   slot_status_type    status_in;
   logic [31:0]        time_in;
   logic [31:0]        period_in;
   logic [15:0]        reps_in;

   assign req_addr = IDX_W'(req_ff.slot_id);
   assign addr     = cmd.walk_step ? idx_ff : req_addr;

   assign cur_status = status_ff[addr];
   assign cur_time   = time_ff[addr];
   assign cur_period = period_ff[addr];
   assign cur_reps   = reps_ff[addr];

   assign status.func        = req_ff.func;
   assign status.in_range    = 6'(req_ff.slot_id) < 6'(SLOTS);
   assign status.period_zero = (req_ff.period == '0);
   assign status.walk_last   = (idx_ff == IDX_W'(SLOTS - 1));

   // one slot per cycle: age, fire and reload
   always_comb begin
      sat_time = (req_ff.elapsed_ticks >= cur_time) ? '0 : cur_time - req_ff.elapsed_ticks;
      st1      = cur_status;
      t1       = cur_time;
      case (cur_status)
         ST_USED: t1  = sat_time;
         ST_NEW:  st1 = ST_USED;
         default: ;
      endcase
      fire  = (st1 == ST_USED) && (t1 == '0);
      st2   = st1;
      t2    = t1;
      reps2 = cur_reps;
      if (fire) begin
         if (cur_reps != '0) begin
            if (!cur_reps[15]) begin
               reps2 = cur_reps - 16'd1;
            end
            t2 = cur_period;
         end
         if (reps2 == '0) begin
            st2 = ST_UNUSED;
         end
      end
   end

   always_comb begin
      wr_en     = 1'b0;
      status_in = cur_status;
      time_in   = cur_time;
      period_in = cur_period;
      reps_in   = cur_reps;
      if (cmd.walk_step) begin
         wr_en     = 1'b1;
         status_in = st2;
         time_in   = t2;
         reps_in   = reps2;
      end else begin
         case (cmd.act)
            ACT_ADD: begin
               wr_en     = 1'b1;
               status_in = ST_NEW;
               time_in   = req_ff.period;
               period_in = req_ff.period;
               reps_in   = req_ff.repeat_count;
            end
            ACT_ZERO_ADD: begin
               wr_en     = 1'b1;
               status_in = ST_UNUSED;
            end
            ACT_REMOVE: begin
               wr_en     = 1'b1;
               status_in = ST_UNUSED;
               time_in   = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i] <= ST_UNUSED;
         end
      end else if (wr_en) begin
         status_ff[addr] <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_ff[addr]   <= time_in;
         period_ff[addr] <= period_in;
         reps_ff[addr]   <= reps_in;
      end
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      cand_time_ff <= t2;
      cand_idx_ff  <= idx_ff;
      rsp_ff       <= rsp_in;
   end

   // walk index and minimum search, one stage behind the slot update
   always_comb begin
      idx_in        = idx_ff;
      cand_valid_in = cmd.walk_step && (st2 == ST_USED);
      best_found_in = best_found_ff;
      best_time_in  = best_time_ff;
      best_idx_in   = best_idx_ff;
      if (cmd.walk_init) begin
         idx_in        = '0;
         best_found_in = 1'b0;
         best_time_in  = NO_CANDIDATE;
         best_idx_in   = '0;
      end else begin
         if (cmd.walk_step) begin
            idx_in = IDX_W'(idx_ff + 1'b1);
         end
         // strict compare keeps the lowest index on ties and skips all-ones
         if (cand_valid_ff && (cand_time_ff < best_time_ff)) begin
            best_found_in = 1'b1;
            best_time_in  = cand_time_ff;
            best_idx_in   = cand_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cand_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         cand_valid_ff <= cand_valid_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_time_ff <= best_time_in;
      best_idx_ff  <= best_idx_in;
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (cmd.walk_step) begin
         if (fire) begin
            rsp_valid_in    = 1'b1;
            rsp_in.kind     = KIND_FIRED;
            rsp_in.event_id = 3'(idx_ff);
         end
      end else begin
         case (cmd.act)
            ACT_ZERO_ADD: begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_FIRED;
               rsp_in.event_id = req_ff.slot_id;
               rsp_in.last     = 1'b1;
            end
            ACT_REMOVE, ACT_REJECT: begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = KIND_DONE;
               rsp_in.last  = 1'b1;
            end
            ACT_QUERY: begin
               rsp_valid_in      = 1'b1;
               rsp_in.kind       = KIND_STATE;
               rsp_in.slot_state = cur_status;
               rsp_in.last       = 1'b1;
            end
            ACT_REPORT: begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_NEXT;
               rsp_in.last     = 1'b1;
               rsp_in.timer_on = best_found_ff;
               if (best_found_ff) begin
                  rsp_in.event_id   = 3'(best_idx_ff);
                  rsp_in.next_delay = best_time_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/event_slot_scheduler.sv]
`default_nettype none

`include "event_slot_scheduler_assert.svh"

// Event slot scheduler. An item is taken when start is high and busy is low;
// busy then stays high until the item's last result is out. Results come on
// rsp_item for one cycle each, marked by rsp_valid, with last set on the final
// one, and must be taken as they come since nothing holds them back. Remove,
// query, rejected requests and zero-period adds give one result, passing
// through the idle and decode states. Add and time elapsed walk the slot
// table one slot per cycle through a single update unit, then a drain state
// finishes the minimum search and a report state gives the result, with
// fired results coming out during the walk.
module event_slot_scheduler #(
   parameter int SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ess_pkg::req_type req_item,
   output logic             rsp_valid,
   output ess_pkg::rsp_type rsp_item
);
   import ess_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ess_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ess_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `ESS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
   `ESS_ASSERT_SAME(a_last_frees, rsp_valid && rsp_item.last, !busy,
      "block still busy on last result")
   `ESS_ASSERT_SAME(a_mid_fired, rsp_valid && !rsp_item.last,
      busy && (rsp_item.kind == KIND_FIRED), "non-final result is not a firing")
   `ESS_ASSERT_SAME(a_walk_cmd, cmd.walk_step, !cmd.capture && (cmd.act == ACT_NONE),
      "slot walk overlaps another command")

endmodule

`default_nettype wire
